FILE: sv/tpdo_pkg.sv
// shared types, constants and helpers for the tpdo trigger and pack block
package tpdo_pkg;

  localparam int PAYLOAD_BYTES = 8;
  localparam int NUM_LANES     = 8;
  localparam int POS_W         = 4;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;

  localparam logic [7:0] TYPE_EVENT      = 8'hFF;
  localparam logic [7:0] TYPE_CYCLIC_MIN = 8'h01;
  localparam logic [7:0] TYPE_CYCLIC_MAX = 8'hF0;

  localparam logic [6:0] NODE_ID_RESET = 7'h01;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_START  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAPPED      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTHS     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID     = 3'd6;

  localparam logic [1:0] LEN_NONE = 2'd0;
  localparam logic [1:0] LEN_8    = 2'd1;
  localparam logic [1:0] LEN_16   = 2'd2;
  localparam logic [1:0] LEN_32   = 2'd3;

  typedef struct packed {
    logic        tpdo_enable;
    logic [7:0]  tx_type;
    logic [15:0] event_period;
    logic [7:0]  sync_start;
    logic [3:0]  mapped_count;
    logic [15:0] length_codes;
    logic [6:0]  node_id;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{node_id: NODE_ID_RESET, default: '0};

  // link between neighboring packing lanes
  typedef struct packed {
    logic             fit;
    logic [POS_W-1:0] pos;
  } lane_link_t;

  function automatic logic [POS_W-1:0] bytes_of_code(input logic [1:0] code);
    logic [POS_W-1:0] n;
    unique case (code)
      LEN_NONE: n = POS_W'(0);
      LEN_8:    n = POS_W'(1);
      LEN_16:   n = POS_W'(2);
      LEN_32:   n = POS_W'(4);
      default:  n = POS_W'(0);
    endcase
    return n;
  endfunction

endpackage

FILE: sv/tpdo_if.sv
// request and result channel interfaces
interface tpdo_req_if;
  logic        valid;
  logic        ready;
  logic [7:0]  sync_count;
  logic [3:0]  func_code;
  logic [31:0] value0;
  logic [31:0] value1;
  logic [31:0] value2;
  logic [31:0] value3;
  logic [31:0] value4;
  logic [31:0] value5;
  logic [31:0] value6;
  logic [31:0] value7;

  modport source (
    output valid, sync_count, func_code,
    output value0, value1, value2, value3, value4, value5, value6, value7,
    input  ready
  );
  modport sink (
    input  valid, sync_count, func_code,
    input  value0, value1, value2, value3, value4, value5, value6, value7,
    output ready
  );
endinterface

interface tpdo_res_if;
  logic        valid;
  logic        ready;
  logic [10:0] frame_id;
  logic [63:0] payload;

  modport source (output valid, frame_id, payload, input ready);
  modport sink (input valid, frame_id, payload, output ready);
endinterface

FILE: sv/tpdo_trigger.sv
// transmit trigger: event timer and cyclic sync phase
module tpdo_trigger (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  tpdo_pkg::cfg_t cfg_i,
  input  logic [7:0]     sync_count_i,
  output logic           fire_o
);

  logic [15:0] event_count_q, event_count_d;
  logic        sync_started_q, sync_started_d;
  logic [7:0]  sync_phase_q, sync_phase_d;

  logic        is_event;
  logic        is_cyclic;
  logic        started_now;
  logic [7:0]  phase_next;
  logic        event_fire;
  logic        cyclic_fire;

  assign is_event  = (cfg_i.tx_type == tpdo_pkg::TYPE_EVENT);
  assign is_cyclic = (cfg_i.tx_type >= tpdo_pkg::TYPE_CYCLIC_MIN) &&
                     (cfg_i.tx_type <= tpdo_pkg::TYPE_CYCLIC_MAX);

  assign event_fire  = (event_count_q >= cfg_i.event_period);
  assign started_now = sync_started_q || (sync_count_i >= cfg_i.sync_start);
  assign phase_next  = (sync_phase_q == cfg_i.tx_type) ? 8'd1
                                                       : sync_phase_q + 8'd1;

  always_comb begin
    event_count_d  = event_count_q;
    sync_started_d = sync_started_q;
    sync_phase_d   = sync_phase_q;
    cyclic_fire    = 1'b0;
    if (is_event) begin
      event_count_d = (event_count_q == cfg_i.event_period) ? 16'd0
                                                            : event_count_q + 16'd1;
    end else if (is_cyclic) begin
      sync_started_d = started_now;
      if (started_now) begin
        sync_phase_d = phase_next;
      end
      cyclic_fire = (sync_phase_d >= cfg_i.tx_type);
    end else begin
      event_count_d  = 16'd0;
      sync_started_d = 1'b0;
      sync_phase_d   = 8'd0;
    end
  end

  assign fire_o = cfg_i.tpdo_enable &&
                  ((is_event && event_fire) || (is_cyclic && cyclic_fire));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      event_count_q  <= 16'd0;
      sync_started_q <= 1'b0;
      sync_phase_q   <= 8'd0;
    end else if (accept_i && cfg_i.tpdo_enable) begin
      event_count_q  <= event_count_d;
      sync_started_q <= sync_started_d;
      sync_phase_q   <= sync_phase_d;
    end
  end

  a_off_type_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && cfg_i.tpdo_enable && !is_event && !is_cyclic) |=>
      (event_count_q == 16'd0) && !sync_started_q && (sync_phase_q == 8'd0))
    else $error("state not cleared for inactive transmission type");

  a_disabled_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && !cfg_i.tpdo_enable) |=>
      $stable(event_count_q) && $stable(sync_started_q) && $stable(sync_phase_q))
    else $error("trigger state moved while disabled");

endmodule

FILE: sv/tpdo_lane.sv
// one packing lane: places one mapped value at its byte offset
module tpdo_lane (
  input  logic                 active_i,
  input  logic [1:0]           code_i,
  input  logic [31:0]          value_i,
  input  tpdo_pkg::lane_link_t link_i,
  output tpdo_pkg::lane_link_t link_o,
  output logic [63:0]          word_o
);

  logic [tpdo_pkg::POS_W-1:0] n;
  logic [tpdo_pkg::POS_W-1:0] end_pos;
  logic                       fits;
  logic [31:0]                masked;

  assign n       = active_i ? tpdo_pkg::bytes_of_code(code_i) : '0;
  assign end_pos = link_i.pos + n;
  assign fits    = link_i.fit && (end_pos <= tpdo_pkg::POS_W'(tpdo_pkg::PAYLOAD_BYTES));

  always_comb begin
    unique case (code_i)
      tpdo_pkg::LEN_8:  masked = {24'd0, value_i[7:0]};
      tpdo_pkg::LEN_16: masked = {16'd0, value_i[15:0]};
      tpdo_pkg::LEN_32: masked = value_i;
      default:          masked = 32'd0;
    endcase
  end

  assign link_o.fit = fits;
  assign link_o.pos = fits ? end_pos : link_i.pos;
  assign word_o     = (fits && active_i) ? (64'(masked) << {link_i.pos[2:0], 3'b000})
                                         : 64'd0;

endmodule

FILE: sv/tpdo_merge.sv
// merge stage: combines the lane words into one payload
module tpdo_merge (
  input  logic [tpdo_pkg::NUM_LANES-1:0][63:0] words_i,
  output logic [63:0]                          payload_o
);

  always_comb begin
    payload_o = 64'd0;
    for (int i = 0; i < tpdo_pkg::NUM_LANES; i++) begin
      payload_o = payload_o | words_i[i];
    end
  end

endmodule

FILE: sv/tpdo_trigger_and_pack.sv
// top level of the tpdo trigger and pack block
//
//  channel   dir   handshake        contents
//  in_i      in    valid / ready    sync_count, func_code, value0..value7
//  out_o     out   valid / ready    frame_id, payload
//  cfg       in    cfg_we_i         cfg_idx_i, cfg_data_i
//
// one request per cycle while in_i.ready is high; trigger, eight packing lanes and merge sit in one stage
// a result is registered and shows on out_o the cycle after its request is taken
// reset clears trigger state and out_o.valid; config resets to zero, node id to one
// in_i.ready drops only while a result is held and out_o.ready is low
module tpdo_trigger_and_pack (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  tpdo_req_if.sink                          in_i,
  tpdo_res_if.source                        out_o,
  input  logic                              cfg_we_i,
  input  logic [tpdo_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tpdo_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  tpdo_pkg::cfg_t cfg_q;

  logic        in_acc;
  logic        fire;
  logic        out_valid_q, out_valid_d;
  logic [10:0] frame_id_q;
  logic [63:0] payload_q;
  logic [63:0] payload;

  logic [tpdo_pkg::NUM_LANES-1:0][31:0] lane_val;
  logic [tpdo_pkg::NUM_LANES-1:0][63:0] lane_word;
  tpdo_pkg::lane_link_t                 link [tpdo_pkg::NUM_LANES+1];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= tpdo_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tpdo_pkg::CFG_ENABLE:     cfg_q.tpdo_enable  <= cfg_data_i[0];
        tpdo_pkg::CFG_TYPE:       cfg_q.tx_type      <= cfg_data_i[7:0];
        tpdo_pkg::CFG_PERIOD:     cfg_q.event_period <= cfg_data_i;
        tpdo_pkg::CFG_SYNC_START: cfg_q.sync_start   <= cfg_data_i[7:0];
        tpdo_pkg::CFG_MAPPED:     cfg_q.mapped_count <= cfg_data_i[3:0];
        tpdo_pkg::CFG_LENGTHS:    cfg_q.length_codes <= cfg_data_i;
        tpdo_pkg::CFG_NODE_ID:    cfg_q.node_id      <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;

  tpdo_trigger u_trigger (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_acc),
    .cfg_i        (cfg_q),
    .sync_count_i (in_i.sync_count),
    .fire_o       (fire)
  );

  assign lane_val[0] = in_i.value0;
  assign lane_val[1] = in_i.value1;
  assign lane_val[2] = in_i.value2;
  assign lane_val[3] = in_i.value3;
  assign lane_val[4] = in_i.value4;
  assign lane_val[5] = in_i.value5;
  assign lane_val[6] = in_i.value6;
  assign lane_val[7] = in_i.value7;

  assign link[0].fit = 1'b1;
  assign link[0].pos = '0;

  for (genvar g = 0; g < tpdo_pkg::NUM_LANES; g++) begin : g_lane
    tpdo_lane u_lane (
      .active_i (cfg_q.mapped_count > 4'(g)),
      .code_i   (cfg_q.length_codes[2*g +: 2]),
      .value_i  (lane_val[g]),
      .link_i   (link[g]),
      .link_o   (link[g+1]),
      .word_o   (lane_word[g])
    );
  end

  tpdo_merge u_merge (
    .words_i   (lane_word),
    .payload_o (payload)
  );

  assign out_valid_d = (out_valid_q && !out_o.ready) || (in_acc && fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && fire) begin
      frame_id_q <= {in_i.func_code, cfg_q.node_id};
      payload_q  <= payload;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.frame_id = frame_id_q;
  assign out_o.payload  = payload_q;

  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && fire) |=> out_valid_q)
    else $error("fired request produced no result");

  a_no_fire_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !fire && out_valid_q && out_o.ready) |=> !out_valid_q)
    else $error("result appeared without a fire");

  a_empty_takes_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("request refused with empty output register");

endmodule

FILE: tb/tpdo_frame_checker.sv
// checker that tracks the tpdo trigger state and compares every emitted frame
`timescale 1ns / 100ps
module tpdo_frame_checker
  import tpdo_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tpdo_req_if                   req_mon,
  tpdo_res_if                   res_mon,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    mismatches_o,
  output int                    frames_owed_o
);

  typedef struct packed {
    logic [10:0] frame_id;
    logic [63:0] payload;
  } frame_t;

  cfg_t        regs;
  logic [15:0] evt_cnt;
  logic        cyc_on;
  logic [7:0]  cyc_phase;
  frame_t      frames_due[$];
  int          mismatches = 0;

  function automatic logic [63:0] packed_data(input cfg_t c, input logic [255:0] vals);
    logic [63:0] data;
    int          pos;
    int          n;
    int          cnt;
    data = '0;
    pos  = 0;
    cnt  = (c.mapped_count > 4'd8) ? 8 : int'(c.mapped_count);
    for (int i = 0; i < cnt; i++) begin
      case (c.length_codes[2*i +: 2])
        LEN_8:   n = 1;
        LEN_16:  n = 2;
        LEN_32:  n = 4;
        default: n = 0;
      endcase
      if (pos + n > PAYLOAD_BYTES) break;
      for (int b = 0; b < n; b++) begin
        data[8*pos +: 8] = vals[32*i + 8*b +: 8];
        pos++;
      end
    end
    return data;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic   fire;
    frame_t want;
    if (!rst_ni) begin
      regs         = '0;
      regs.node_id = NODE_ID_RESET;
      evt_cnt      = '0;
      cyc_on       = 1'b0;
      cyc_phase    = '0;
      frames_due.delete();
    end else begin
      // result side first: a result always belongs to an earlier request
      if (res_mon.valid && res_mon.ready) begin
        if (frames_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected frame: id %h payload %h", res_mon.frame_id,
                     res_mon.payload);
        end else begin
          want = frames_due.pop_front();
          if (res_mon.frame_id !== want.frame_id || res_mon.payload !== want.payload) begin
            mismatches++;
            if (mismatches <= 10)
              $display("frame mismatch: id exp %h got %h, payload exp %h got %h",
                       want.frame_id, res_mon.frame_id, want.payload, res_mon.payload);
          end
        end
      end

      if (req_mon.valid && req_mon.ready && regs.tpdo_enable) begin
        fire = 1'b0;
        if (regs.tx_type == TYPE_EVENT) begin
          fire = (evt_cnt >= regs.event_period);
          if (evt_cnt == regs.event_period) evt_cnt = '0;
          else evt_cnt = evt_cnt + 16'd1;
        end else if (regs.tx_type >= TYPE_CYCLIC_MIN &&
                     regs.tx_type <= TYPE_CYCLIC_MAX) begin
          if (req_mon.sync_count >= regs.sync_start) cyc_on = 1'b1;
          if (cyc_on) begin
            if (cyc_phase == regs.tx_type) cyc_phase = 8'd1;
            else cyc_phase = cyc_phase + 8'd1;
          end
          fire = (cyc_phase >= regs.tx_type);
        end else begin
          evt_cnt   = '0;
          cyc_on    = 1'b0;
          cyc_phase = '0;
        end
        if (fire) begin
          want.frame_id = {req_mon.func_code, regs.node_id};
          want.payload  = packed_data(regs, {req_mon.value7, req_mon.value6, req_mon.value5,
                                             req_mon.value4, req_mon.value3, req_mon.value2,
                                             req_mon.value1, req_mon.value0});
          frames_due.push_back(want);
        end
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ENABLE:     regs.tpdo_enable  = cfg_data_i[0];
          CFG_TYPE:       regs.tx_type      = cfg_data_i[7:0];
          CFG_PERIOD:     regs.event_period = cfg_data_i[15:0];
          CFG_SYNC_START: regs.sync_start   = cfg_data_i[7:0];
          CFG_MAPPED:     regs.mapped_count = cfg_data_i[3:0];
          CFG_LENGTHS:    regs.length_codes = cfg_data_i[15:0];
          CFG_NODE_ID:    regs.node_id      = cfg_data_i[6:0];
          default: ;
        endcase
      end
    end
    mismatches_o  = mismatches;
    frames_owed_o = frames_due.size();
  end

endmodule

FILE: tb/tpdo_trigger_and_pack_tb.sv
// top of the tpdo trigger and pack testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
module tpdo_trigger_and_pack_tb;
  import tpdo_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    mismatches;
  int                    frames_owed;
  int                    reqs_sent = 0;
  int                    hold_asked = 0;
  int                    hold_done = 0;
  bit                    quiet = 1'b0;

  tpdo_req_if req ();
  tpdo_res_if res ();

  tpdo_trigger_and_pack dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (req),
    .out_o      (res),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  tpdo_frame_checker chk (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .req_mon       (req),
    .res_mon       (res),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .mismatches_o  (mismatches),
    .frames_owed_o (frames_owed)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic logic [255:0] rand_values();
    logic [255:0] v;
    for (int i = 0; i < 8; i++) begin
      case ($urandom_range(0, 9))
        0:       v[32*i +: 32] = '0;
        1:       v[32*i +: 32] = '1;
        default: v[32*i +: 32] = $urandom;
      endcase
    end
    return v;
  endfunction

  function automatic cfg_t rand_cfg();
    cfg_t c;
    int   pick;
    c.tpdo_enable = ($urandom_range(0, 9) != 0);
    pick = $urandom_range(0, 99);
    if (pick < 45) c.tx_type = TYPE_EVENT;
    else if (pick < 80) c.tx_type = 8'($urandom_range(1, 6));
    else if (pick < 90)
      c.tx_type = 8'($urandom_range(TYPE_CYCLIC_MIN, TYPE_CYCLIC_MAX));
    else if (pick < 95)
      c.tx_type = 8'($urandom_range(int'(TYPE_CYCLIC_MAX) + 1,
                                    int'(TYPE_EVENT) - 1));
    else c.tx_type = '0;
    pick = $urandom_range(0, 99);
    if (pick < 70) c.event_period = 16'($urandom_range(0, 5));
    else if (pick < 95) c.event_period = 16'($urandom_range(0, 40));
    else if (pick < 97) c.event_period = '1;
    else c.event_period = 16'($urandom);
    c.sync_start = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 30)) : 8'($urandom);
    c.mapped_count = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(9, 15))
                                                 : 4'($urandom_range(0, 8));
    c.length_codes = 16'($urandom);
    c.node_id      = 7'($urandom);
    return c;
  endfunction

  // entered and left at a falling edge; valid stays high unless a gap follows
  task automatic send_req(input logic [7:0] sc, input logic [3:0] fc,
                          input logic [255:0] vals);
    int gap;
    int pick;
    pick = $urandom_range(0, 99);
    if (quiet || pick < 60) gap = 0;
    else if (pick < 94) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      req.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.valid      = 1'b1;
    req.sync_count = sc;
    req.func_code  = fc;
    req.value0     = vals[31:0];
    req.value1     = vals[63:32];
    req.value2     = vals[95:64];
    req.value3     = vals[127:96];
    req.value4     = vals[159:128];
    req.value5     = vals[191:160];
    req.value6     = vals[223:192];
    req.value7     = vals[255:224];
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    reqs_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic apply_cfg(input cfg_t c);
    write_reg(CFG_ENABLE, CFG_DATA_W'(c.tpdo_enable));
    write_reg(CFG_TYPE, CFG_DATA_W'(c.tx_type));
    write_reg(CFG_PERIOD, c.event_period);
    write_reg(CFG_SYNC_START, CFG_DATA_W'(c.sync_start));
    write_reg(CFG_MAPPED, CFG_DATA_W'(c.mapped_count));
    write_reg(CFG_LENGTHS, c.length_codes);
    write_reg(CFG_NODE_ID, CFG_DATA_W'(c.node_id));
  endtask

  // block idle: waits until nothing is owed, then lets a request with no result drain
  task automatic settle();
    req.valid = 1'b0;
    while (frames_owed != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // result side: random ready, and one long hold-off when asked
  initial begin
    int span;
    int pick;
    res.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_done < hold_asked) begin
        res.ready = 1'b0;
        span = 300;
        hold_done++;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          res.ready = 1'b1;
          span = $urandom_range(1, 40);
        end else if (pick < 92) begin
          res.ready = 1'b0;
          span = $urandom_range(1, 3);
        end else begin
          res.ready = 1'b0;
          span = $urandom_range(10, 60);
        end
      end
      repeat (span) @(negedge clk);
    end
  end

  initial begin
    cfg_t c;
    int   n;
    int   ph;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = '0;
    cfg_data       = '0;
    req.valid      = 1'b0;
    req.sync_count = '0;
    req.func_code  = '0;
    req.value0     = '0;
    req.value1     = '0;
    req.value2     = '0;
    req.value3     = '0;
    req.value4     = '0;
    req.value5     = '0;
    req.value6     = '0;
    req.value7     = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // disabled after reset
    send_req(8'hFF, 4'hF, '1);
    send_req(8'h00, 4'h0, '0);
    settle();

    // event driven, fires every call; 32-bit entries overflow after two
    c              = '0;
    c.tpdo_enable  = 1'b1;
    c.tx_type      = TYPE_EVENT;
    c.mapped_count = 4'd8;
    c.length_codes = {8{LEN_32}};
    c.node_id      = 7'h7F;
    apply_cfg(c);
    send_req(8'h00, 4'h0, '1);
    send_req(8'hFF, 4'hF, '0);
    send_req(8'h5A, 4'hA, rand_values());
    settle();

    // eight bytes filled exactly, node id zero
    c.length_codes = {8{LEN_8}};
    c.node_id      = '0;
    apply_cfg(c);
    send_req(8'h01, 4'h5, rand_values());
    send_req(8'h02, 4'hF, '1);
    settle();

    // mapped count above eight, none entries in between, overflow mid-way
    c.mapped_count = 4'hF;
    c.length_codes = {LEN_8, LEN_32, LEN_NONE, LEN_16, LEN_8, LEN_NONE, LEN_32, LEN_16};
    apply_cfg(c);
    send_req(8'h10, 4'h3, rand_values());
    send_req(8'h20, 4'hC, '1);
    settle();

    c.mapped_count = '0;
    apply_cfg(c);
    send_req(8'h30, 4'h7, '1);
    settle();

    c.mapped_count = 4'd4;
    c.length_codes = {8{LEN_16}};
    apply_cfg(c);
    send_req(8'h40, 4'h9, rand_values());
    settle();

    // largest period, then lowered below the running count
    c.event_period = '1;
    apply_cfg(c);
    send_req(8'h50, 4'h1, rand_values());
    settle();
    c.event_period = 16'd6;
    apply_cfg(c);
    repeat (4) send_req(8'($urandom), 4'($urandom), rand_values());
    settle();
    c.event_period = 16'd2;
    apply_cfg(c);
    repeat (2) send_req(8'($urandom), 4'($urandom), rand_values());
    settle();

    // cyclic every sync
    c.tx_type    = TYPE_CYCLIC_MIN;
    c.sync_start = '0;
    apply_cfg(c);
    repeat (2) send_req(8'($urandom), 4'($urandom), rand_values());
    settle();

    // type just above the cyclic range clears state
    c.tx_type = TYPE_CYCLIC_MAX + 8'd1;
    apply_cfg(c);
    send_req(8'h00, 4'h2, rand_values());
    settle();

    // largest cyclic type, start threshold at its top
    c.tx_type    = TYPE_CYCLIC_MAX;
    c.sync_start = '1;
    apply_cfg(c);
    send_req(8'hFE, 4'h6, rand_values());
    send_req(8'hFF, 4'h6, rand_values());
    settle();

    c.tx_type = '0;
    apply_cfg(c);
    send_req(8'hFF, 4'hB, rand_values());

    ph = 0;
    while (reqs_sent < 1150) begin
      settle();
      quiet = ($urandom_range(0, 3) == 0);
      n = $urandom_range(20, 90);
      if (ph == 2) begin
        // long cyclic run, stopped just short of the type
        c             = rand_cfg();
        c.tpdo_enable = 1'b1;
        c.tx_type     = 8'd100;
        c.sync_start  = '0;
        n = 95;
      end else if (ph == 3) begin
        // type lowered under the phase: fires until the phase wraps
        c.tx_type = 8'd3;
        n = 170;
      end else if (ph == 5) begin
        c              = rand_cfg();
        c.tpdo_enable  = 1'b1;
        c.tx_type      = TYPE_EVENT;
        c.event_period = '0;
        quiet = 1'b1;
        n = 120;
        hold_asked++;
      end else begin
        c = rand_cfg();
      end
      apply_cfg(c);
      repeat (n) send_req(8'($urandom), 4'($urandom), rand_values());
      ph++;
    end
    settle();
    repeat (10) @(negedge clk);

    if (mismatches == 0 && frames_owed == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
